@@ rtl/core/cpsc_pkg.sv @@
// Shared types and constants for the cross power spectrum block.
// No dependencies; every other file but cpsc_ram imports this package.
`default_nettype none
package cpsc_pkg;

  localparam int MAX_ROW_LEN = 64;
  localparam int MAX_ROWS    = 64;
  localparam int STORE_DEPTH = MAX_ROW_LEN * MAX_ROWS;

  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int COL_W    = $clog2(MAX_ROW_LEN);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 2;
  localparam int SAMPLE_W = 16;
  localparam int WORD_W   = 2 * SAMPLE_W;
  localparam int PROD_W   = 17;
  localparam int MUL_W    = 2 * SAMPLE_W;
  localparam int ACC_W    = MUL_W + 2;
  localparam int FRAC_SHIFT = 15;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CORR = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ENABLE = 2'd2;

  typedef struct packed {
    logic [CFG_W-1:0] row_length;
    logic [CFG_W-1:0] row_count;
    logic             center_enable;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] ref_re;
    logic signed [SAMPLE_W-1:0] ref_im;
    logic signed [SAMPLE_W-1:0] s_re;
    logic signed [SAMPLE_W-1:0] s_im;
    logic                       negate;
    logic                       last;
  } job_t;

  typedef struct packed {
    logic              valid;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/cpsc_if.sv @@
// Valid/ready channel interfaces for input samples and product results.
// Depends on cpsc_pkg.
`default_nettype none
interface cpsc_in_if import cpsc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic signed [SAMPLE_W-1:0] sample_re;
  logic signed [SAMPLE_W-1:0] sample_im;

  modport source(output valid, op, sample_re, sample_im, input ready);
  modport sink(input valid, op, sample_re, sample_im, output ready);
endinterface

interface cpsc_out_if import cpsc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [PROD_W-1:0] prod_re;
  logic signed [PROD_W-1:0] prod_im;
  logic                     frame_last;

  modport source(output valid, prod_re, prod_im, frame_last, input ready);
  modport sink(input valid, prod_re, prod_im, frame_last, output ready);
endinterface
`default_nettype wire

@@ rtl/core/cross_power_spectrum_centered_top.sv @@
// Path: a result passes through the store read, queue, multiply and output register
// after its sample is accepted; queued jobs and backpressure delay it further.
// Throughput: one sample per cycle while the job queue has room, load or correlate;
// the reference store sees one write or one read per cycle.
// Reset: registers return to 64 samples, 64 rows, centering on; positions
// clear. Reference store contents are undefined until loaded (no clear pass).
`default_nettype none
module cross_power_spectrum_centered_top import cpsc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  cpsc_in_if.sink                   sample_ch,
  cpsc_out_if.source                result_ch
);

  cfg_t              cfg;
  q_stat_t           q_stat;
  job_t              push_job, head;
  logic              push, pop;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_length    <= CFG_W'(MAX_ROW_LEN);
      cfg.row_count     <= CFG_W'(MAX_ROWS);
      cfg.center_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_LENGTH:    cfg.row_length    <= cfg_data;
        REG_ROW_COUNT:     cfg.row_count     <= cfg_data;
        REG_CENTER_ENABLE: cfg.center_enable <= cfg_data[0];
        default:           cfg <= cfg;
      endcase
    end
  end

  cpsc_ram #(.WIDTH(WORD_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cpsc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .sample_ch (sample_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_job  (push_job),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  cpsc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .stat     (q_stat),
    .head     (head)
  );

  cpsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .result_ch (result_ch)
  );

endmodule
`default_nettype wire

@@ rtl/core/cpsc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module cpsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/cpsc_front.sv @@
// Front end: accepts samples, loads the reference store, tracks raster
// position and issues store reads. Depends on cpsc_pkg and cpsc_if.
`default_nettype none
module cpsc_front import cpsc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire cfg_t         cfg,
  cpsc_in_if.sink           sample_ch,
  input  wire q_stat_t      q_stat,
  output logic              push,
  output job_t              push_job,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [WORD_W-1:0] ram_wdata,
  output logic [ADDR_W-1:0] ram_raddr,
  input  wire logic [WORD_W-1:0] ram_rdata
);

  localparam int TOT_W  = 2 * CFG_W;
  localparam int AFUL_W = ROW_W + CFG_W + 1;

  logic [CFG_W-1:0]  len, rows;
  logic [TOT_W-1:0]  total;
  logic [ADDR_W-1:0] load_pos;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic              col_end, row_end, accept;
  logic [AFUL_W-1:0] addr_full;

  // Held between the read issue and the registered store data
  logic                       f_valid;
  logic signed [SAMPLE_W-1:0] f_re, f_im;
  logic                       f_neg, f_last;

  always_comb begin
    if (cfg.row_length == '0) begin
      len = CFG_W'(1);
    end else if (cfg.row_length > CFG_W'(MAX_ROW_LEN)) begin
      len = CFG_W'(MAX_ROW_LEN);
    end else begin
      len = cfg.row_length;
    end
    if (cfg.row_count == '0) begin
      rows = CFG_W'(1);
    end else if (cfg.row_count > CFG_W'(MAX_ROWS)) begin
      rows = CFG_W'(MAX_ROWS);
    end else begin
      rows = cfg.row_count;
    end
  end

  assign total     = TOT_W'(len) * TOT_W'(rows);
  assign col_end   = (CFG_W'(col) + CFG_W'(1)) >= len;
  assign row_end   = (CFG_W'(row) + CFG_W'(1)) >= rows;
  assign addr_full = AFUL_W'(row) * AFUL_W'(len) + AFUL_W'(col);

  // Reserve a queue slot for the read already in flight
  assign sample_ch.ready = (QCNT_W'(q_stat.count) + QCNT_W'(f_valid)) < QCNT_W'(QDEPTH);
  assign accept          = sample_ch.valid && sample_ch.ready;

  assign ram_we    = accept && (sample_ch.op == OP_LOAD);
  assign ram_waddr = load_pos;
  assign ram_wdata = {sample_ch.sample_im, sample_ch.sample_re};
  assign ram_raddr = addr_full[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
      col      <= '0;
      row      <= '0;
      f_valid  <= 1'b0;
    end else begin
      f_valid <= accept && (sample_ch.op == OP_CORR);
      if (accept) begin
        if (sample_ch.op == OP_LOAD) begin
          if ((TOT_W'(load_pos) + TOT_W'(1)) >= total) begin
            load_pos <= '0;
          end else begin
            load_pos <= load_pos + ADDR_W'(1);
          end
        end else begin
          if (col_end) begin
            col <= '0;
            row <= row_end ? '0 : row + ROW_W'(1);
          end else begin
            col <= col + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (sample_ch.op == OP_CORR)) begin
      f_re   <= sample_ch.sample_re;
      f_im   <= sample_ch.sample_im;
      f_neg  <= cfg.center_enable && (col[0] ^ row[0]);
      f_last <= col_end && row_end;
    end
  end

  assign push            = f_valid;
  assign push_job.ref_re = ram_rdata[SAMPLE_W-1:0];
  assign push_job.ref_im = ram_rdata[WORD_W-1:SAMPLE_W];
  assign push_job.s_re   = f_re;
  assign push_job.s_im   = f_im;
  assign push_job.negate = f_neg;
  assign push_job.last   = f_last;

endmodule
`default_nettype wire

@@ rtl/core/cpsc_queue.sv @@
// Short job queue between front and back ends.
// Depends on cpsc_pkg.
`default_nettype none
module cpsc_queue import cpsc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output q_stat_t   stat,
  output job_t      head
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  assign stat.valid = (count != '0);
  assign stat.count = count;
  assign head       = mem[rd_ptr];

endmodule
`default_nettype wire

@@ rtl/core/cpsc_back.sv @@
// Back end: complex multiply by the conjugate, centering sign, scaling
// and saturation into the output register. Depends on cpsc_pkg, cpsc_if.
`default_nettype none
module cpsc_back import cpsc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire q_stat_t q_stat,
  input  wire job_t    head,
  output logic         pop,
  cpsc_out_if.source   result_ch
);

  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(2 ** (PROD_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(-(2 ** (PROD_W - 1)));

  function automatic logic signed [PROD_W-1:0] scale_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] sh;
    sh = v >>> FRAC_SHIFT;
    if (sh > ACC_MAX) begin
      return ACC_MAX[PROD_W-1:0];
    end else if (sh < ACC_MIN) begin
      return ACC_MIN[PROD_W-1:0];
    end
    return sh[PROD_W-1:0];
  endfunction

  logic                    b_valid, b_neg, b_last;
  logic signed [MUL_W-1:0] rr, ii, ir, ri;
  logic                    o_load, b_load;
  logic signed [ACC_W-1:0] sum_re, sum_im, acc_re, acc_im;

  assign o_load = !result_ch.valid || result_ch.ready;
  assign b_load = !b_valid || o_load;
  assign pop    = b_load && q_stat.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid         <= 1'b0;
      result_ch.valid <= 1'b0;
    end else begin
      if (b_load) begin
        b_valid <= q_stat.valid;
      end
      if (o_load) begin
        result_ch.valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rr     <= head.ref_re * head.s_re;
      ii     <= head.ref_im * head.s_im;
      ir     <= head.ref_im * head.s_re;
      ri     <= head.ref_re * head.s_im;
      b_neg  <= head.negate;
      b_last <= head.last;
    end
  end

  always_comb begin
    sum_re = ACC_W'(rr) + ACC_W'(ii);
    sum_im = ACC_W'(ir) - ACC_W'(ri);
    acc_re = b_neg ? -sum_re : sum_re;
    acc_im = b_neg ? -sum_im : sum_im;
  end

  always_ff @(posedge clk) begin
    if (o_load && b_valid) begin
      result_ch.prod_re    <= scale_sat(acc_re);
      result_ch.prod_im    <= scale_sat(acc_im);
      result_ch.frame_last <= b_last;
    end
  end

endmodule
`default_nettype wire

@@ verif/cross_power_spectrum_centered_top_tb.sv @@
// Self-checking testbench for cross_power_spectrum_centered_top: loads reference spectra,
// streams correlation samples under several frame sizes and checks every product.
// Depends on cpsc_pkg and the cpsc_in_if / cpsc_out_if channel interfaces.
module cross_power_spectrum_centered_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cpsc_pkg::*;

  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [PROD_W-1:0]   P_MIN = 17'sh10000;
  localparam logic signed [PROD_W-1:0]   P_MAX = 17'sh0FFFF;
  localparam longint PROD_HI = (longint'(1) <<< (PROD_W - 1)) - 1;
  localparam longint PROD_LO = -(longint'(1) <<< (PROD_W - 1));
  localparam int     SETTLE_CYCLES = 8;

  typedef struct packed {
    logic signed [PROD_W-1:0] re;
    logic signed [PROD_W-1:0] im;
    logic                     last;
  } cross_product_t;

  // One stimulus row; preset rows carry a hand-derived product.
  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic                       preset;
    logic signed [PROD_W-1:0]   want_re;
    logic signed [PROD_W-1:0]   want_im;
    logic                       want_last;
  } spectrum_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  cpsc_in_if  sample_ch ();
  cpsc_out_if result_ch ();

  cross_power_spectrum_centered_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
  );

  // Reference load at addresses 0..8, then correlate positions 0..7 of row 0.
  spectrum_row_t directed_rows [17] = '{
    '{OP_LOAD, S_MIN,       S_MIN,        1'b0, '0, '0, 1'b0},
    '{OP_LOAD, S_MIN,       S_MIN,        1'b0, '0, '0, 1'b0},
    '{OP_LOAD, 16'sd1,      16'sd0,       1'b0, '0, '0, 1'b0},
    '{OP_LOAD, 16'sd1,      16'sd0,       1'b0, '0, '0, 1'b0},
    '{OP_LOAD, S_MAX,       16'sd0,       1'b0, '0, '0, 1'b0},
    '{OP_LOAD, 16'sd0,      S_MIN,        1'b0, '0, '0, 1'b0},
    '{OP_LOAD, 16'sd12345,  -16'sd23456,  1'b0, '0, '0, 1'b0},
    '{OP_LOAD, -16'sd1,     -16'sd1,      1'b0, '0, '0, 1'b0},
    '{OP_LOAD, S_MAX,       S_MAX,        1'b0, '0, '0, 1'b0},
    '{OP_CORR, S_MIN,       S_MIN,        1'b1, P_MAX,       17'sd0,  1'b0},
    '{OP_CORR, S_MIN,       S_MIN,        1'b1, P_MIN,       17'sd0,  1'b0},
    '{OP_CORR, -16'sd1,     16'sd0,       1'b1, -17'sd1,     17'sd0,  1'b0},
    '{OP_CORR, 16'sd0,      -16'sd1,      1'b1, 17'sd0,      -17'sd1, 1'b0},
    '{OP_CORR, S_MAX,       16'sd0,       1'b1, 17'sd32766,  17'sd0,  1'b0},
    '{OP_CORR, 16'sd0,      S_MAX,        1'b1, 17'sd32767,  17'sd0,  1'b0},
    '{OP_CORR, S_MIN,       S_MAX,        1'b0, '0, '0, 1'b0},
    '{OP_CORR, S_MAX,       S_MIN,        1'b0, '0, '0, 1'b0}
  };

  // Sizes never shrink after the first step, so a read address is always reachable.
  cfg_t setting_plan [7] = '{
    '{7'd0,   7'd1,   1'b0},
    '{7'd3,   7'd0,   1'b1},
    '{7'd5,   7'd3,   1'b1},
    '{7'd7,   7'd6,   1'b0},
    '{7'd16,  7'd9,   1'b1},
    '{7'd127, 7'd12,  1'b0},
    '{7'd64,  7'd127, 1'b1}
  };

  // Expected-behavior state
  cfg_t                       model_cfg = '{7'd64, 7'd64, 1'b1};
  logic signed [SAMPLE_W-1:0] ref_re_mem [STORE_DEPTH];
  logic signed [SAMPLE_W-1:0] ref_im_mem [STORE_DEPTH];
  bit                         ref_loaded [STORE_DEPTH];
  int unsigned                load_pos = 0;
  int unsigned                col_pos = 0;
  int unsigned                row_pos = 0;

  cross_product_t pending_products [$];

  int unsigned burst_left = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_tick = 0;
  int unsigned fault_count = 0;
  int unsigned samples_sent = 0;
  int unsigned loads_sent = 0;
  int unsigned products_seen = 0;
  int unsigned frame_ends = 0;
  int unsigned settings_done = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int unsigned span(input logic [CFG_W-1:0] v, input int unsigned limit);
    if (v == '0) return 1;
    return (v > limit) ? limit : int'(v);
  endfunction

  function automatic int unsigned corr_address(input cfg_t c);
    return (row_pos * span(c.row_length, MAX_ROW_LEN) + col_pos) % STORE_DEPTH;
  endfunction

  function automatic logic signed [PROD_W-1:0] shift_saturate(input longint v);
    longint q;
    q = v >>> FRAC_SHIFT;
    if (q > PROD_HI) q = PROD_HI;
    if (q < PROD_LO) q = PROD_LO;
    return q[PROD_W-1:0];
  endfunction

  // Advance the expected state by one sample; returns 1 when a product results.
  function automatic bit predict_cross_product(input logic op,
                                               input logic signed [SAMPLE_W-1:0] re,
                                               input logic signed [SAMPLE_W-1:0] im,
                                               output cross_product_t p);
    int unsigned len, rows, addr;
    longint      rre, rim, sre, sim, pre, pim;
    bit          col_end, row_end;
    len  = span(model_cfg.row_length, MAX_ROW_LEN);
    rows = span(model_cfg.row_count, MAX_ROWS);
    p    = '0;
    if (op == OP_LOAD) begin
      ref_re_mem[load_pos] = re;
      ref_im_mem[load_pos] = im;
      ref_loaded[load_pos] = 1'b1;
      load_pos = (load_pos + 1 >= len * rows) ? 0 : load_pos + 1;
      return 1'b0;
    end
    addr = corr_address(model_cfg);
    rre  = ref_re_mem[addr];
    rim  = ref_im_mem[addr];
    sre  = re;
    sim  = im;
    pre  = rre * sre + rim * sim;
    pim  = rim * sre - rre * sim;
    if (model_cfg.center_enable && ((col_pos + row_pos) % 2 == 1)) begin
      pre = -pre;
      pim = -pim;
    end
    col_end = (col_pos + 1 >= len);
    row_end = (row_pos + 1 >= rows);
    p.re    = shift_saturate(pre);
    p.im    = shift_saturate(pim);
    p.last  = col_end && row_end;
    if (col_end) begin
      col_pos = 0;
      row_pos = row_end ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
    return 1'b1;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 9))
      0:       return S_MIN;
      1:       return S_MAX;
      2:       return '0;
      3:       return -16'sd1;
      default: return r[SAMPLE_W-1:0];
    endcase
  endfunction

  function automatic void note_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Entered and left at a falling edge.
  task automatic push_sample(input spectrum_row_t row);
    int unsigned    gap;
    cross_product_t p;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        sample_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    sample_ch.valid     <= 1'b1;
    sample_ch.op        <= row.op;
    sample_ch.sample_re <= row.re;
    sample_ch.sample_im <= row.im;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
    if (predict_cross_product(row.op, row.re, row.im, p)) begin
      if (row.preset) begin
        p.re   = row.want_re;
        p.im   = row.want_im;
        p.last = row.want_last;
      end
      pending_products.push_back(p);
    end
    samples_sent++;
    if (row.op == OP_LOAD) loads_sent++;
    @(negedge clk);
  endtask

  task automatic program_setting(input cfg_t c);
    sample_ch.valid <= 1'b0;
    while (pending_products.size() != 0) @(negedge clk);
    // loads leave nothing to wait on, so give the pipeline time to empty
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROW_LENGTH;
    cfg_data  <= c.row_length;
    @(negedge clk);
    cfg_index <= REG_ROW_COUNT;
    cfg_data  <= c.row_count;
    @(negedge clk);
    cfg_index <= REG_CENTER_ENABLE;
    cfg_data  <= CFG_W'(c.center_enable);
    @(negedge clk);
    cfg_we    <= 1'b0;
    model_cfg = c;
    settings_done++;
  endtask

  // Keep going past the count until the next setting would start on a loaded entry.
  task automatic run_random(input int unsigned count, input cfg_t next_cfg);
    spectrum_row_t row;
    int unsigned   n;
    n = 0;
    while (n < count || !ref_loaded[corr_address(next_cfg)]) begin
      row    = '0;
      row.op = ($urandom_range(0, 9) < 3) ? OP_LOAD : OP_CORR;
      // never read an entry that holds nothing yet
      if (row.op == OP_CORR && !ref_loaded[corr_address(model_cfg)]) row.op = OP_LOAD;
      row.re = pick_sample();
      row.im = pick_sample();
      push_sample(row);
      n++;
    end
  endtask

  task automatic check_product(input cross_product_t got);
    cross_product_t want;
    products_seen++;
    if (got.last) frame_ends++;
    if (pending_products.size() == 0) begin
      note_fault($sformatf("product with nothing pending: re %0d im %0d last %0b",
                           got.re, got.im, got.last));
      return;
    end
    want = pending_products.pop_front();
    if (got.re !== want.re || got.im !== want.im || got.last !== want.last)
      note_fault($sformatf("product %0d: expected re %0d im %0d last %0b, got re %0d im %0d last %0b",
                           products_seen, want.re, want.im, want.last,
                           got.re, got.im, got.last));
  endtask

  always @(posedge clk) begin
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
      check_product('{result_ch.prod_re, result_ch.prod_im, result_ch.frame_last});
  end

  // Receiver: periodically switch to a randomly chosen stall style
  always @(negedge clk) begin
    rx_tick++;
    if (rx_tick % 97 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0:       result_ch.ready <= 1'b1;
      1:       result_ch.ready <= ($urandom_range(0, 1) == 1);
      2:       result_ch.ready <= (rx_tick % 5 != 0);
      default: result_ch.ready <= ((rx_tick / 7) % 3 != 0);
    endcase
  end

  initial begin
    int unsigned k;
    sample_ch.valid     = 1'b0;
    sample_ch.op        = OP_LOAD;
    sample_ch.sample_re = '0;
    sample_ch.sample_im = '0;
    result_ch.ready     = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = REG_ROW_LENGTH;
    cfg_data            = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) push_sample(directed_rows[i]);

    for (k = 0; k < 7; k++) begin
      program_setting(setting_plan[k]);
      run_random($urandom_range(80, 120), setting_plan[(k < 6) ? k + 1 : k]);
    end
    sample_ch.valid <= 1'b0;

    for (k = 0; k < 20000 && pending_products.size() != 0; k++) @(negedge clk);
    repeat (SETTLE_CYCLES + 2) @(negedge clk);
    if (pending_products.size() != 0)
      note_fault($sformatf("%0d products never arrived", pending_products.size()));

    $display("Sent %0d samples (%0d reference loads) across %0d register settings.",
             samples_sent, loads_sent, settings_done + 1);
    $display("Checked %0d products including %0d frame ends; %0d faults.",
             products_seen, frame_ends, fault_count);
    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ cross_power_spectrum_centered_top.f @@
rtl/core/cpsc_pkg.sv
rtl/core/cpsc_if.sv
rtl/core/cpsc_ram.sv
rtl/core/cpsc_front.sv
rtl/core/cpsc_queue.sv
rtl/core/cpsc_back.sv
rtl/core/cross_power_spectrum_centered_top.sv
verif/cross_power_spectrum_centered_top_tb.sv
